[rtl/core/mhsp_pkg.sv]
`default_nettype none
package mhsp_pkg;

  localparam int unsigned LONG_ADDR_BYTES = 8;
  localparam int unsigned POS_W = 6;
  localparam int unsigned MAX_HDR_LEN = 37;

  localparam int unsigned FC_SEC_EN_BIT = 3;
  localparam int unsigned FC_INTRA_BIT = 6;
  localparam int unsigned FC_DMODE_LSB = 10;
  localparam int unsigned FC_SMODE_LSB = 14;
  localparam int unsigned SCF_KID_LSB = 3;

  localparam logic [1:0] ADDR_MODE_NONE = 2'd0;
  localparam logic [1:0] ADDR_MODE_SHORT = 2'd2;

  localparam logic [1:0] KID_MODE_NONE = 2'd0;
  localparam logic [1:0] KID_MODE_ONE = 2'd1;
  localparam logic [1:0] KID_MODE_FOUR = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] frame_control;
    logic [7:0]  seq_num;
    logic [15:0] dst_pan;
    logic [63:0] dst_addr;
    logic [15:0] src_pan;
    logic [63:0] src_addr;
    logic [7:0]  sec_control;
    logic [31:0] sec_counter;
    pos_t        header_len;
  } result_t;

  typedef struct packed {
    pos_t da;
    pos_t sp;
    pos_t sa;
    pos_t sc;
    pos_t end_pos;
  } layout_t;

  function automatic pos_t addr_size(input logic [1:0] mode);
    pos_t len;
    case (mode)
      ADDR_MODE_NONE:  len = pos_t'(0);
      ADDR_MODE_SHORT: len = pos_t'(2);
      default:         len = pos_t'(LONG_ADDR_BYTES);
    endcase
    return len;
  endfunction

  function automatic pos_t kid_len(input logic [1:0] mode);
    pos_t len;
    case (mode)
      KID_MODE_NONE: len = pos_t'(0);
      KID_MODE_ONE:  len = pos_t'(1);
      KID_MODE_FOUR: len = pos_t'(4);
      default:       len = pos_t'(9);
    endcase
    return len;
  endfunction

  function automatic layout_t calc_layout(input logic [15:0] fc, input logic [7:0] scf);
    layout_t    l;
    logic [1:0] dmode;
    logic [1:0] smode;
    dmode = fc[FC_DMODE_LSB +: 2];
    smode = fc[FC_SMODE_LSB +: 2];
    l.da = pos_t'(3) + ((dmode != ADDR_MODE_NONE) ? pos_t'(2) : pos_t'(0));
    l.sp = l.da + addr_size(dmode);
    l.sa = l.sp + (((smode != ADDR_MODE_NONE) && !fc[FC_INTRA_BIT]) ? pos_t'(2) : pos_t'(0));
    l.sc = l.sa + addr_size(smode);
    l.end_pos = fc[FC_SEC_EN_BIT] ? (l.sc + pos_t'(5) + kid_len(scf[SCF_KID_LSB +: 2]))
                                  : l.sc;
    return l;
  endfunction

endpackage
`default_nettype wire

[rtl/core/mhsp_in_reg.sv]
`default_nettype none
module mhsp_in_reg
  import mhsp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire logic  [7:0] data_byte_i,
  input  wire logic  frame_end_i,
  input  wire logic  advance_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte <= data_byte_i;
      item_q.frame_end <= frame_end_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

[rtl/core/mhsp_parse.sv]
`default_nettype none
module mhsp_parse
  import mhsp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  advance_i,
  input  wire item_t item_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  pos_t        pos_q, pos_d, pos_s;
  logic        done_q, done_d;
  logic [15:0] fc_q, fc_d, fc_s;
  logic [7:0]  seq_q, seq_d, seq_s;
  logic [15:0] dpan_q, dpan_d, dpan_s;
  logic [63:0] daddr_q, daddr_d, daddr_s;
  logic [15:0] span_q, span_d, span_s;
  logic [63:0] saddr_q, saddr_d, saddr_s;
  logic [7:0]  scf_q, scf_d, scf_s;
  logic [31:0] ctr_q, ctr_d, ctr_s;

  layout_t lay_q, lay_s;
  pos_t    off_dp, off_da, off_sp, off_sa, off_ct;
  logic [7:0] b;
  logic    complete;

  assign b = item_i.data_byte;
  assign lay_q = calc_layout(fc_q, scf_q);
  assign off_dp = pos_q - pos_t'(3);
  assign off_da = pos_q - lay_q.da;
  assign off_sp = pos_q - lay_q.sp;
  assign off_sa = pos_q - lay_q.sa;
  assign off_ct = pos_q - lay_q.sc - pos_t'(1);

  // byte store at the current position
  always_comb begin
    fc_s = fc_q;
    seq_s = seq_q;
    dpan_s = dpan_q;
    daddr_s = daddr_q;
    span_s = span_q;
    saddr_s = saddr_q;
    scf_s = scf_q;
    ctr_s = ctr_q;
    pos_s = pos_q;
    if (!done_q) begin
      pos_s = pos_q + pos_t'(1);
      if (pos_q == pos_t'(0)) begin
        fc_s[7:0] = b;
      end else if (pos_q == pos_t'(1)) begin
        fc_s[15:8] = b;
      end else if (pos_q == pos_t'(2)) begin
        seq_s = b;
      end else if (pos_q < lay_q.da) begin
        dpan_s[{off_dp[0], 3'b000} +: 8] = b;
      end else if (pos_q < lay_q.sp) begin
        daddr_s[{off_da[2:0], 3'b000} +: 8] = b;
      end else if (pos_q < lay_q.sa) begin
        span_s[{off_sp[0], 3'b000} +: 8] = b;
      end else if (pos_q < lay_q.sc) begin
        saddr_s[{off_sa[2:0], 3'b000} +: 8] = b;
      end else if (pos_q == lay_q.sc) begin
        scf_s = b;
      end else if (pos_q < lay_q.sc + pos_t'(5)) begin
        ctr_s[{off_ct[1:0], 3'b000} +: 8] = b;
      end
    end
  end

  assign lay_s = calc_layout(fc_s, scf_s);
  assign complete = !done_q && (pos_s >= pos_t'(3)) && (pos_s == lay_s.end_pos);

  always_comb begin
    res_o = '0;
    res_valid_o = 1'b0;
    if (complete) begin
      res_valid_o = 1'b1;
      res_o.status = STATUS_OK;
      res_o.frame_control = fc_s;
      res_o.seq_num = seq_s;
      res_o.dst_pan = dpan_s;
      res_o.dst_addr = daddr_s;
      res_o.src_pan = fc_s[FC_INTRA_BIT] ? dpan_s : span_s;
      res_o.src_addr = saddr_s;
      res_o.sec_control = scf_s;
      res_o.sec_counter = ctr_s;
      res_o.header_len = pos_s;
    end else if (!done_q && item_i.frame_end) begin
      res_valid_o = 1'b1;
      res_o.status = STATUS_TRUNC;
    end
  end

  // frame end restarts the parser
  always_comb begin
    if (item_i.frame_end) begin
      pos_d = '0;
      done_d = 1'b0;
      fc_d = '0;
      seq_d = '0;
      dpan_d = '0;
      daddr_d = '0;
      span_d = '0;
      saddr_d = '0;
      scf_d = '0;
      ctr_d = '0;
    end else begin
      pos_d = pos_s;
      done_d = done_q || complete;
      fc_d = fc_s;
      seq_d = seq_s;
      dpan_d = dpan_s;
      daddr_d = daddr_s;
      span_d = span_s;
      saddr_d = saddr_s;
      scf_d = scf_s;
      ctr_d = ctr_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      done_q <= 1'b0;
      fc_q <= '0;
      seq_q <= '0;
      dpan_q <= '0;
      daddr_q <= '0;
      span_q <= '0;
      saddr_q <= '0;
      scf_q <= '0;
      ctr_q <= '0;
    end else if (advance_i) begin
      pos_q <= pos_d;
      done_q <= done_d;
      fc_q <= fc_d;
      seq_q <= seq_d;
      dpan_q <= dpan_d;
      daddr_q <= daddr_d;
      span_q <= span_d;
      saddr_q <= saddr_d;
      scf_q <= scf_d;
      ctr_q <= ctr_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mhsp_out_reg.sv]
`default_nettype none
module mhsp_out_reg
  import mhsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    item_valid_i,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  output logic         advance_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = item_valid_i && !(valid_q && out_stall_i);

  always_comb begin
    if (advance_o) begin
      valid_d = res_valid_i;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

[rtl/core/mac_header_stream_parser.sv]
// 802.15.4 mac header parser, receive side
// input channel: one frame byte per item on data_byte_i, frame_end_i marks
// the last byte of a frame; accepted when in_valid_i is high and in_stall_o low
// output channel: one result item when the header is complete (status 0, all
// header fields, header_len) or when the frame ends first (status 1, rest zero);
// trailing bytes after the header give no item
// path: an accepted item is parsed from the input register into the output
// register behind out_valid_o; throughput: one byte per cycle while out_stall_i
// holds no waiting result, set by the single register-to-register parse path;
// a result leaving the output register does not slow the next byte
// stall: when out_stall_i holds a waiting result, the parse stage stops and
// in_stall_o rises once the input register is full; no item is lost
// reset: rst_ni clears both channels' valid flags and the parser state, and
// the next byte is taken as byte 0 of a frame
`default_nettype none
module mac_header_stream_parser
  import mhsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic [15:0]      frame_control_o,
  output logic [7:0]       seq_num_o,
  output logic [15:0]      dst_pan_o,
  output logic [63:0]      dst_addr_o,
  output logic [15:0]      src_pan_o,
  output logic [63:0]      src_addr_o,
  output logic [7:0]       sec_control_o,
  output logic [31:0]      sec_counter_o,
  output logic [5:0]       header_len_o
);

  logic    advance;
  logic    item_valid;
  item_t   item;
  logic    res_valid;
  result_t res;
  result_t res_out;

  mhsp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mhsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mhsp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res_out)
  );

  assign status_o = res_out.status;
  assign frame_control_o = res_out.frame_control;
  assign seq_num_o = res_out.seq_num;
  assign dst_pan_o = res_out.dst_pan;
  assign dst_addr_o = res_out.dst_addr;
  assign src_pan_o = res_out.src_pan;
  assign src_addr_o = res_out.src_addr;
  assign sec_control_o = res_out.sec_control;
  assign sec_counter_o = res_out.sec_counter;
  assign header_len_o = res_out.header_len;

endmodule
`default_nettype wire

[rtl/core/mhsp_checker.sv]
`default_nettype none
module mhsp_checker
  import mhsp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        status_o,
  input wire logic [15:0] frame_control_o,
  input wire logic [5:0]  header_len_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(frame_control_o)
      && $stable(header_len_o))
    else $error("stalled result item changed");

  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_trunc_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_TRUNC) |->
      (header_len_o == 6'd0) && (frame_control_o == 16'd0))
    else $error("truncation item carries header data");

  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_OK) |->
      (header_len_o >= 6'd3) && (header_len_o <= 6'(MAX_HDR_LEN)))
    else $error("header length out of range");

endmodule

bind mac_header_stream_parser mhsp_checker u_mhsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .frame_control_o (frame_control_o),
  .header_len_o    (header_len_o)
);
`default_nettype wire

[tb/sv/tb_mac_header_stream_parser.sv]
`default_nettype none
module tb_mac_header_stream_parser;
  import mhsp_pkg::*;

  localparam logic [1:0] ADDR_MODE_LONG = 2'd3;
  localparam logic [1:0] KID_MODE_NINE = 2'd3;

  class header_checker;
    pos_t        cur_pos;
    bit          hdr_done;
    logic [15:0] fc_w;
    logic [7:0]  seq_b;
    logic [15:0] dpan_w;
    logic [63:0] daddr_w;
    logic [15:0] span_w;
    logic [63:0] saddr_w;
    logic [7:0]  sec_ctl;
    logic [31:0] fcnt_w;
    result_t     expected_hdrs[$];
    int          errors;
    int          parsed_cnt;
    int          trunc_cnt;
    int          checked_cnt;

    function new();
      restart();
    endfunction

    function void restart();
      cur_pos = '0;
      hdr_done = 1'b0;
      fc_w = '0;
      seq_b = '0;
      dpan_w = '0;
      daddr_w = '0;
      span_w = '0;
      saddr_w = '0;
      sec_ctl = '0;
      fcnt_w = '0;
    endfunction

    static function int addr_bytes(logic [1:0] m);
      case (m)
        ADDR_MODE_NONE:  return 0;
        ADDR_MODE_SHORT: return 2;
        default:         return LONG_ADDR_BYTES;
      endcase
    endfunction

    static function int kid_bytes(logic [1:0] m);
      case (m)
        KID_MODE_NONE: return 0;
        KID_MODE_ONE:  return 1;
        KID_MODE_FOUR: return 4;
        default:       return 9;
      endcase
    endfunction

    // start of each header field; returns the header length
    static function int field_starts(input logic [15:0] fc, input logic [7:0] scf,
                                     output int da, output int sp, output int sa,
                                     output int sc);
      logic [1:0] dm;
      logic [1:0] sm;
      dm = fc[FC_DMODE_LSB +: 2];
      sm = fc[FC_SMODE_LSB +: 2];
      da = 3 + ((dm != ADDR_MODE_NONE) ? 2 : 0);
      sp = da + addr_bytes(dm);
      sa = sp + (((sm != ADDR_MODE_NONE) && !fc[FC_INTRA_BIT]) ? 2 : 0);
      sc = sa + addr_bytes(sm);
      return fc[FC_SEC_EN_BIT] ? (sc + 5 + kid_bytes(scf[SCF_KID_LSB +: 2])) : sc;
    endfunction

    function void store(int p, logic [7:0] b);
      int da, sp, sa, sc, hlen;
      hlen = field_starts(fc_w, sec_ctl, da, sp, sa, sc);
      if (p == 0) begin
        fc_w[7:0] = b;
      end else if (p == 1) begin
        fc_w[15:8] = b;
      end else if (p == 2) begin
        seq_b = b;
      end else if (p < da) begin
        dpan_w |= 16'(b) << (8 * ((p - 3) % 2));
      end else if (p < sp) begin
        daddr_w |= 64'(b) << (8 * ((p - da) % 8));
      end else if (p < sa) begin
        span_w |= 16'(b) << (8 * ((p - sp) % 2));
      end else if (p < sc) begin
        saddr_w |= 64'(b) << (8 * ((p - sa) % 8));
      end else if (p == sc) begin
        sec_ctl = b;
      end else if (p < sc + 5) begin
        fcnt_w |= 32'(b) << (8 * ((p - sc - 1) % 4));
      end
      // key id bytes are skipped
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      result_t r;
      int da, sp, sa, sc, need;
      if (!hdr_done) begin
        store(int'(cur_pos), b);
        cur_pos = cur_pos + pos_t'(1);
        need = field_starts(fc_w, sec_ctl, da, sp, sa, sc);
        if (cur_pos >= pos_t'(3) && cur_pos == pos_t'(need)) begin
          hdr_done = 1'b1;
          r.status = STATUS_OK;
          r.frame_control = fc_w;
          r.seq_num = seq_b;
          r.dst_pan = dpan_w;
          r.dst_addr = daddr_w;
          r.src_pan = fc_w[FC_INTRA_BIT] ? dpan_w : span_w;
          r.src_addr = saddr_w;
          r.sec_control = sec_ctl;
          r.sec_counter = fcnt_w;
          r.header_len = cur_pos;
          expected_hdrs.push_back(r);
          parsed_cnt++;
        end else if (last) begin
          r = '0;
          r.status = STATUS_TRUNC;
          expected_hdrs.push_back(r);
          trunc_cnt++;
        end
      end
      if (last) restart();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("header %0d: %s is %h, expected %h", checked_cnt, name, got, want));
    endtask

    task check_header(result_t got);
      result_t want;
      if (expected_hdrs.size() == 0) begin
        report($sformatf("unexpected header item, status %0d fc %h",
                         got.status, got.frame_control));
        return;
      end
      want = expected_hdrs.pop_front();
      cmp("status", 64'(got.status), 64'(want.status));
      cmp("frame_control", 64'(got.frame_control), 64'(want.frame_control));
      cmp("seq_num", 64'(got.seq_num), 64'(want.seq_num));
      cmp("dst_pan", 64'(got.dst_pan), 64'(want.dst_pan));
      cmp("dst_addr", got.dst_addr, want.dst_addr);
      cmp("src_pan", 64'(got.src_pan), 64'(want.src_pan));
      cmp("src_addr", got.src_addr, want.src_addr);
      cmp("sec_control", 64'(got.sec_control), 64'(want.sec_control));
      cmp("sec_counter", 64'(got.sec_counter), 64'(want.sec_counter));
      cmp("header_len", 64'(got.header_len), 64'(want.header_len));
      checked_cnt++;
    endtask

    task flush_check();
      if (expected_hdrs.size() != 0)
        report($sformatf("%0d header items never came out", expected_hdrs.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        status;
  logic [15:0] frame_control;
  logic [7:0]  seq_num;
  logic [15:0] dst_pan;
  logic [63:0] dst_addr;
  logic [15:0] src_pan;
  logic [63:0] src_addr;
  logic [7:0]  sec_control;
  logic [31:0] sec_counter;
  logic [5:0]  header_len;

  header_checker hc;
  logic [7:0]    frame_q[$];
  int            burst_left = 0;
  bit            idle_on = 1'b1;
  int            bytes_sent = 0;
  int            frames_sent = 0;
  int            drains = 0;

  mac_header_stream_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .frame_end_i     (frame_end),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .frame_control_o (frame_control),
    .seq_num_o       (seq_num),
    .dst_pan_o       (dst_pan),
    .dst_addr_o      (dst_addr),
    .src_pan_o       (src_pan),
    .src_addr_o      (src_addr),
    .sec_control_o   (sec_control),
    .sec_counter_o   (sec_counter),
    .header_len_o    (header_len)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern, switching at random among three stall modes
  initial begin
    int  run_left;
    bit  hold;
    int  stall_mode;
    int  cyc;
    run_left = 0;
    hold = 1'b0;
    stall_mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (cyc % 80 == 0) stall_mode = $urandom_range(0, 2);
      cyc++;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left == 0) begin
            hold = !hold;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          out_stall = hold;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.status = status;
      got.frame_control = frame_control;
      got.seq_num = seq_num;
      got.dst_pan = dst_pan;
      got.dst_addr = dst_addr;
      got.src_pan = src_pan;
      got.src_addr = src_addr;
      got.sec_control = sec_control;
      got.sec_counter = sec_counter;
      got.header_len = header_len;
      hc.check_header(got);
    end
  end

  task send_item(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        data_byte = 8'($urandom);
        frame_end = 1'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    data_byte = b;
    frame_end = last;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    hc.take_byte(b, last);
    bytes_sent++;
  endtask

  task send_frame();
    foreach (frame_q[i]) send_item(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // hold the sender until every header item has come out
  task drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (hc.expected_hdrs.size() != 0) @(negedge clk);
    drains++;
  endtask

  task build_random_frame();
    logic [15:0] fc;
    logic [7:0]  scf;
    int          da, sp, sa, sc, hlen, len, kind;
    fc = 16'($urandom);
    scf = 8'($urandom);
    // longest header shape now and then
    if ($urandom_range(0, 99) < 15) begin
      fc[FC_SEC_EN_BIT] = 1'b1;
      fc[FC_INTRA_BIT] = 1'b0;
      fc[FC_DMODE_LSB +: 2] = ADDR_MODE_LONG;
      fc[FC_SMODE_LSB +: 2] = ADDR_MODE_LONG;
      scf[SCF_KID_LSB +: 2] = KID_MODE_NINE;
    end
    hlen = header_checker::field_starts(fc, scf, da, sp, sa, sc);
    kind = $urandom_range(0, 99);
    if (kind < 10) len = $urandom_range(1, 40);
    else if (kind < 30) len = $urandom_range(1, hlen - 1);
    else len = hlen + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    if (kind >= 10) begin
      frame_q[0] = fc[7:0];
      if (len > 1) frame_q[1] = fc[15:8];
      if (fc[FC_SEC_EN_BIT] && sc < len) frame_q[sc] = scf;
    end
  endtask

  initial begin
    int waited;
    hc = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single byte frame, minimal header, compression without destination
    // or without source address, security header cut short
    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'h00, 8'h00, 8'hA5};
    send_frame();
    frame_q = '{8'h40, 8'h80, 8'h11, 8'h34, 8'h12, 8'hEE};
    send_frame();
    frame_q = '{8'h40, 8'h08, 8'h22, 8'hCD, 8'hAB, 8'h78, 8'h56};
    send_frame();
    frame_q = '{8'h08, 8'h00, 8'h33, 8'h18, 8'h01, 8'h02};
    send_frame();

    while (bytes_sent < 650) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_random_frame();
      send_frame();
      if (frames_sent % 12 == 5) drain_results();
    end

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (hc.expected_hdrs.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    hc.flush_check();

    $display("sent %0d bytes in %0d frames, sender held for drain %0d times",
             bytes_sent, frames_sent, drains);
    $display("checked %0d header items: %0d parsed, %0d truncated, %0d mismatches",
             hc.checked_cnt, hc.parsed_cnt, hc.trunc_cnt, hc.errors);
    if (hc.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
